/* src/kefx_pkg.sv */
// ----------------------------------------------------------------------------
// kefx_pkg
// Shared types, codes and helpers for the keypad entry / SPI frame exchange.
// ----------------------------------------------------------------------------
package kefx_pkg;

   // Transaction kinds on the request channel
   localparam logic REQ_KEY = 1'b0;
   localparam logic REQ_SPI = 1'b1;

   // Key codes; digits are 0 up to KEY_DIGIT_MAX
   localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
   localparam logic [3:0] KEY_STAR      = 4'd10;
   localparam logic [3:0] KEY_HASH      = 4'd11;
   localparam logic [3:0] KEY_A         = 4'd12;
   localparam logic [3:0] KEY_B         = 4'd13;
   localparam logic [3:0] KEY_C         = 4'd14;
   localparam logic [3:0] KEY_D         = 4'd15;

   // Frame byte positions
   localparam logic [1:0] POS_HEAD  = 2'd0;
   localparam logic [1:0] POS_HIGH  = 2'd1;
   localparam logic [1:0] POS_LOW   = 2'd2;
   localparam logic [1:0] POS_CHECK = 2'd3;

   localparam logic [7:0]  FRAME_HEAD  = 8'hA5;
   localparam logic [15:0] ENTRY_MAX   = 16'd9999;
   localparam logic [2:0]  DIGIT_LIMIT = 3'd4;
   // ceil(2^19 / 10): exact quotient for any 16-bit dividend
   localparam logic [16:0] DIV10_MUL   = 17'd52429;
   localparam int          DIV10_SHIFT = 19;

   typedef struct packed {
      logic [15:0] value;
      logic [2:0]  digits;
   } entry_stat_type;

   typedef struct packed {
      logic [7:0]  miso;
      logic [15:0] received;
      logic        done;
      logic        good;
   } frame_stat_type;

   function automatic logic [7:0] reply_byte(input logic [15:0] num, input logic [1:0] pos);
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] res;
      hi = num[15:8];
      lo = num[7:0];
      unique case (pos)
         POS_HEAD:  res = FRAME_HEAD;
         POS_HIGH:  res = hi;
         POS_LOW:   res = lo;
         POS_CHECK: res = FRAME_HEAD ^ hi ^ lo;
         default:   res = FRAME_HEAD;
      endcase
      return res;
   endfunction

endpackage

/* src/kefx_entry.sv */
// ----------------------------------------------------------------------------
// kefx_entry
// Local keypad entry: digit append, clear, backspace, step up/down, confirm.
// ----------------------------------------------------------------------------
module kefx_entry (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [3:0]              key,
   output kefx_pkg::entry_stat_type stat,
   output logic [15:0]             confirmed
);
   import kefx_pkg::*;

   logic [15:0] entry_ff, entry_in;
   logic [2:0]  digits_ff, digits_in;
   logic [15:0] confirmed_ff, confirmed_in;
   logic [32:0] div_prod;
   logic [15:0] entry_x10;
   logic [15:0] entry_div10;

   assign entry_x10   = {entry_ff[12:0], 3'b000} + {entry_ff[14:0], 1'b0} + {12'd0, key};
   assign div_prod    = 33'(entry_ff) * 33'(DIV10_MUL);
   assign entry_div10 = {2'b00, div_prod[32:DIV10_SHIFT]};

   always_comb begin
      entry_in     = entry_ff;
      digits_in    = digits_ff;
      confirmed_in = confirmed_ff;
      if (step) begin
         priority if (key <= KEY_DIGIT_MAX) begin
            if (digits_ff < DIGIT_LIMIT) begin
               entry_in  = entry_x10;
               digits_in = digits_ff + 3'd1;
            end
         end else if (key == KEY_STAR || key == KEY_D) begin
            entry_in  = '0;
            digits_in = '0;
         end else if (key == KEY_A) begin
            entry_in = entry_div10;
            if (digits_ff != 3'd0) begin
               digits_in = digits_ff - 3'd1;
            end
         end else if (key == KEY_B) begin
            if (entry_ff < ENTRY_MAX) begin
               entry_in = entry_ff + 16'd1;
            end
         end else if (key == KEY_C) begin
            if (entry_ff != 16'd0) begin
               entry_in = entry_ff - 16'd1;
            end
         end else begin
            // hash: confirm the entry
            confirmed_in = entry_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff     <= '0;
         digits_ff    <= '0;
         confirmed_ff <= '0;
      end else begin
         entry_ff     <= entry_in;
         digits_ff    <= digits_in;
         confirmed_ff <= confirmed_in;
      end
   end

   assign stat.value  = entry_in;
   assign stat.digits = digits_in;
   assign confirmed   = confirmed_ff;

endmodule

/* src/kefx_frame.sv */
// ----------------------------------------------------------------------------
// kefx_frame
// SPI frame receiver with header/XOR check and reply frame preload.
// ----------------------------------------------------------------------------
module kefx_frame (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    is_spi,
   input  logic [7:0]              rx_byte,
   input  logic [15:0]             confirmed,
   output kefx_pkg::frame_stat_type stat
);
   import kefx_pkg::*;

   logic [7:0]  rx_bytes_ff [3];
   logic [1:0]  pos_ff, pos_in;
   logic [15:0] latched_ff, latched_in;
   logic [15:0] reply_ff, reply_in;
   logic [7:0]  chk;
   logic        rx_wr;
   logic        done;
   logic        good;
   logic [7:0]  miso;

   assign chk = rx_bytes_ff[0] ^ rx_bytes_ff[1] ^ rx_bytes_ff[2];

   always_comb begin
      pos_in     = pos_ff;
      latched_in = latched_ff;
      reply_in   = reply_ff;
      rx_wr      = 1'b0;
      done       = 1'b0;
      good       = 1'b0;
      miso       = reply_byte(reply_ff, pos_ff);
      if (step && is_spi) begin
         if (pos_ff != POS_CHECK) begin
            rx_wr  = 1'b1;
            pos_in = pos_ff + 2'd1;
            miso   = reply_byte(reply_ff, pos_in);
         end else begin
            done = 1'b1;
            if (rx_bytes_ff[0] == FRAME_HEAD && rx_byte == chk) begin
               good       = 1'b1;
               latched_in = {rx_bytes_ff[1], rx_bytes_ff[2]};
            end
            // reply rebuilt whether or not the frame was good
            reply_in = confirmed;
            pos_in   = POS_HEAD;
            miso     = FRAME_HEAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_HEAD;
         latched_ff <= '0;
         reply_ff   <= '0;
      end else begin
         pos_ff     <= pos_in;
         latched_ff <= latched_in;
         reply_ff   <= reply_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rx_wr) begin
         rx_bytes_ff[pos_ff] <= rx_byte;
      end
   end

   assign stat.miso     = miso;
   assign stat.received = latched_in;
   assign stat.done     = done;
   assign stat.good     = good;

endmodule

/* src/keypad_entry_spi_frame_exchange.sv */
// ----------------------------------------------------------------------------
// keypad_entry_spi_frame_exchange
// Keypad number entry with a framed SPI slave exchange, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): each transaction is either a
//   decoded key (req_type = 0, req_key_code) or a byte received from the
//   SPI master (req_type = 1, req_spi_byte).
//   Response channel (rsp_valid / rsp_stall): exactly one transaction per
//   request, in order, carrying the next MISO byte to preload, the local
//   entry and digit count, the number from the last good frame and the
//   frame done / good flags.
//   Path: a request taken into the input register is offered on the
//   response side once its result is in the result register.
//   Throughput: one transaction per cycle while the response is not
//   stalled; entry and frame state update between the two registers.
//   Stall: while the response is stalled the result register holds; one
//   more request is taken into the input register, after which req_stall
//   rises until the response moves.
//   Reset: synchronous, clears entry, confirmed and received numbers, frame
//   position and reply frame; both register stages come up empty.
// ----------------------------------------------------------------------------
module keypad_entry_spi_frame_exchange (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [3:0]  req_key_code,
   input  logic [7:0]  req_spi_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_miso_byte,
   output logic [15:0] rsp_entry_value,
   output logic [2:0]  rsp_entry_digits,
   output logic [15:0] rsp_received_value,
   output logic        rsp_frame_done,
   output logic        rsp_frame_good
);
   import kefx_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic           in_type_ff;
   logic [3:0]     in_key_ff;
   logic [7:0]     in_byte_ff;
   logic           out_valid_ff, out_valid_in;
   logic           advance;
   logic           req_fire;
   logic [15:0]    confirmed;
   entry_stat_type entry_stat;
   frame_stat_type frame_stat;
   entry_stat_type entry_out_ff;
   frame_stat_type frame_out_ff;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   kefx_entry u_entry (
      .clock     (clock),
      .reset     (reset),
      .step      (advance && (in_type_ff == REQ_KEY)),
      .key       (in_key_ff),
      .stat      (entry_stat),
      .confirmed (confirmed)
   );

   kefx_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .is_spi    (in_type_ff == REQ_SPI),
      .rx_byte   (in_byte_ff),
      .confirmed (confirmed),
      .stat      (frame_stat)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_type_ff <= req_type;
         in_key_ff  <= req_key_code;
         in_byte_ff <= req_spi_byte;
      end
      if (advance) begin
         entry_out_ff <= entry_stat;
         frame_out_ff <= frame_stat;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_miso_byte      = frame_out_ff.miso;
   assign rsp_entry_value    = entry_out_ff.value;
   assign rsp_entry_digits   = entry_out_ff.digits;
   assign rsp_received_value = frame_out_ff.received;
   assign rsp_frame_done     = frame_out_ff.done;
   assign rsp_frame_good     = frame_out_ff.good;

endmodule

/* src/kefx_checker.sv */
// ----------------------------------------------------------------------------
// kefx_checker
// Port-level checks for the keypad entry / SPI frame exchange.
// ----------------------------------------------------------------------------
module kefx_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_miso_byte,
   input logic [2:0]  rsp_entry_digits,
   input logic        rsp_frame_done,
   input logic        rsp_frame_good
);
   import kefx_pkg::*;

   // nothing offered straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a good frame is always a completed frame
   a_good_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_good |-> rsp_frame_done)
      else $error("frame_good without frame_done");

   // end of frame restarts the reply with its header
   a_done_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_miso_byte == FRAME_HEAD)
      else $error("reply header not preloaded at frame end");

   a_digits_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_digits <= DIGIT_LIMIT)
      else $error("digit count beyond limit");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_miso_byte)
         && $stable(rsp_frame_done))
      else $error("stalled response changed");

endmodule

bind keypad_entry_spi_frame_exchange kefx_checker u_kefx_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_miso_byte    (rsp_miso_byte),
   .rsp_entry_digits (rsp_entry_digits),
   .rsp_frame_done   (rsp_frame_done),
   .rsp_frame_good   (rsp_frame_good)
);
